FILE: rtl/uartrb_pkg.sv
// ----------------------------------------------------------------------------
// uartrb_pkg
// Shared types and constants for the UART receive/transmit ring buffers.
// ----------------------------------------------------------------------------
package uartrb_pkg;

    localparam int FIFO_DEPTH_DEF = 32;
    localparam int OUT_W          = 40;

    typedef enum logic [1:0] {
        REQ_LINE_RX  = 2'd0,
        REQ_TX_DONE  = 2'd1,
        REQ_HOST_WR  = 2'd2,
        REQ_HOST_RD  = 2'd3
    } t_req_kind;

    // controller to datapath commands
    typedef struct packed {
        logic start;     // event accepted this cycle
        logic load_out;  // capture the result into the output register
    } t_cmd;

endpackage

FILE: rtl/uart_rx_tx_ring_buffers_top.sv
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_top
// UART ring buffers: receive and transmit FIFOs serving one event at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries events: tuser[1:0] is the kind (line byte received,
//   transmit done, host write, host read), tdata[7:0] the byte.
//   Master stream returns one result per event with the popped host byte,
//   the byte handed to the line, overflow/reject flags, busy mark and both
//   FIFO levels after the event.
//   For each event the transfer cycle updates pointers and starts the FIFO
//   memory read; the result register is then loaded once it is free. A new
//   event is accepted only after the previous result has been loaded.
//   The result register lets the next event enter while a result still
//   waits. If the receiver stalls, the following event is accepted and then
//   waits for the result register to free up, with s_axis_tready low.
//   Reset clears pointers, counts, the busy mark and the result valid; the
//   FIFO storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_top #(
    parameter int FIFO_DEPTH = uartrb_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] byte_in
    input  logic [1:0]                    s_axis_tuser,   // [1:0] req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] read_byte, [8] read_valid, [9] line_load, [17:10] line_byte,
    // [18] rx_overflow, [19] tx_reject, [20] tx_busy, [26:21] rx_level,
    // [32:27] tx_level, [39:33] zero
    output logic [uartrb_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam logic [5:0] FULL_LVL = 6'(FIFO_DEPTH);

    uartrb_pkg::t_cmd cmd;

    uartrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    uartrb_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_kind  (uartrb_pkg::t_req_kind'(s_axis_tuser)),
        .i_byte  (s_axis_tdata),
        .o_data  (m_axis_tdata)
    );

    // at most one event outcome flag per result
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0({m_axis_tdata[8], m_axis_tdata[9],
                                    m_axis_tdata[18], m_axis_tdata[19]}))
        else $error("more than one outcome flag in a result");

    // a dropped line byte means the receive FIFO sits at full level
    a_ovf_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[18]) |-> (m_axis_tdata[26:21] == FULL_LVL))
        else $error("rx overflow without full receive level");

    // bytes queue only while the transmitter is busy
    a_tx_queue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[32:27] != 6'd0)) |-> m_axis_tdata[20])
        else $error("transmit queue not empty while idle");

    // a new event is never taken while the previous one is still in work
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("event accepted back to back");

endmodule

FILE: rtl/uartrb_ctrl.sv
// ----------------------------------------------------------------------------
// uartrb_ctrl
// Sequencer: accepts one event, lets the memory read data register, then
// loads the result register when it is free.
// ----------------------------------------------------------------------------
module uartrb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output uartrb_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        n_out_valid    = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                // result register free, or its transfer completes now
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/uartrb_dp.sv
// ----------------------------------------------------------------------------
// uartrb_dp
// Datapath: two ring FIFOs with pointers and counts, the busy mark, and the
// result register.
// ----------------------------------------------------------------------------
module uartrb_dp #(
    parameter int FIFO_DEPTH = uartrb_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  uartrb_pkg::t_cmd              i_cmd,
    input  uartrb_pkg::t_req_kind         i_kind,
    input  logic [7:0]                    i_byte,
    output logic [uartrb_pkg::OUT_W-1:0]  o_data
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    logic [7:0] r_rx_mem [FIFO_DEPTH];
    logic [7:0] r_tx_mem [FIFO_DEPTH];
    logic [7:0] r_rx_rdata, r_tx_rdata;

    logic [AW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [AW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [CW-1:0] r_rx_count, n_rx_count, r_tx_count, n_tx_count;
    logic          r_sending, n_sending;

    logic rx_we, rx_re, tx_we, tx_re;
    logic rd_valid, ld, ld_mem, ovf, rej;

    // per-event flags, held until the result is loaded
    logic       r_rd_valid, r_ld, r_ld_mem, r_ovf, r_rej;
    logic [7:0] r_byte;
    logic [uartrb_pkg::OUT_W-1:0] r_out;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
        next_idx = (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    always_comb begin
        n_rx_head  = r_rx_head;
        n_rx_tail  = r_rx_tail;
        n_rx_count = r_rx_count;
        n_tx_head  = r_tx_head;
        n_tx_tail  = r_tx_tail;
        n_tx_count = r_tx_count;
        n_sending  = r_sending;
        rx_we = 1'b0; rx_re = 1'b0; tx_we = 1'b0; tx_re = 1'b0;
        rd_valid = 1'b0; ld = 1'b0; ld_mem = 1'b0; ovf = 1'b0; rej = 1'b0;
        if (i_cmd.start) begin
            unique case (i_kind)
                uartrb_pkg::REQ_LINE_RX: begin
                    if (r_rx_count < FULL_CNT) begin
                        rx_we      = 1'b1;
                        n_rx_tail  = next_idx(r_rx_tail);
                        n_rx_count = r_rx_count + CW'(1);
                    end else begin
                        ovf = 1'b1;
                    end
                end
                uartrb_pkg::REQ_TX_DONE: begin
                    if (r_tx_count != '0) begin
                        ld         = 1'b1;
                        ld_mem     = 1'b1;
                        tx_re      = 1'b1;
                        n_tx_head  = next_idx(r_tx_head);
                        n_tx_count = r_tx_count - CW'(1);
                    end else begin
                        n_sending = 1'b0;
                    end
                end
                uartrb_pkg::REQ_HOST_WR: begin
                    // full check comes before the idle test
                    if (r_tx_count >= FULL_CNT) begin
                        rej = 1'b1;
                    end else if (!r_sending) begin
                        ld        = 1'b1;
                        n_sending = 1'b1;
                    end else begin
                        tx_we      = 1'b1;
                        n_tx_tail  = next_idx(r_tx_tail);
                        n_tx_count = r_tx_count + CW'(1);
                    end
                end
                uartrb_pkg::REQ_HOST_RD: begin
                    if (r_rx_count != '0) begin
                        rd_valid   = 1'b1;
                        rx_re      = 1'b1;
                        n_rx_head  = next_idx(r_rx_head);
                        n_rx_count = r_rx_count - CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[r_rx_tail] <= i_byte;
        end
        if (rx_re) begin
            r_rx_rdata <= r_rx_mem[r_rx_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[r_tx_tail] <= i_byte;
        end
        if (tx_re) begin
            r_tx_rdata <= r_tx_mem[r_tx_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head  <= '0;
            r_rx_tail  <= '0;
            r_rx_count <= '0;
            r_tx_head  <= '0;
            r_tx_tail  <= '0;
            r_tx_count <= '0;
            r_sending  <= 1'b0;
        end else begin
            r_rx_head  <= n_rx_head;
            r_rx_tail  <= n_rx_tail;
            r_rx_count <= n_rx_count;
            r_tx_head  <= n_tx_head;
            r_tx_tail  <= n_tx_tail;
            r_tx_count <= n_tx_count;
            r_sending  <= n_sending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rd_valid <= rd_valid;
            r_ld       <= ld;
            r_ld_mem   <= ld_mem;
            r_ovf      <= ovf;
            r_rej      <= rej;
            r_byte     <= i_byte;
        end
    end

    // counts and busy mark are already updated when the result is loaded
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out[7:0]   <= r_rd_valid ? r_rx_rdata : 8'd0;
            r_out[8]     <= r_rd_valid;
            r_out[9]     <= r_ld;
            r_out[17:10] <= r_ld ? (r_ld_mem ? r_tx_rdata : r_byte) : 8'd0;
            r_out[18]    <= r_ovf;
            r_out[19]    <= r_rej;
            r_out[20]    <= r_sending;
            r_out[26:21] <= 6'(r_rx_count);
            r_out[32:27] <= 6'(r_tx_count);
            r_out[uartrb_pkg::OUT_W-1:33] <= '0;
        end
    end

    assign o_data = r_out;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UART receive/transmit ring buffers. Events go
// in on the slave stream in random bursts. A behavioral copy of both FIFOs
// and the busy mark steps with every event; its prediction, or the expected
// result of a directed row, is queued. Results on the master stream, which
// stalls on its own pattern, are compared against the oldest queued result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH       = uartrb_pkg::FIFO_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_EVENTS = 1250;

    localparam uartrb_pkg::t_req_kind EV_LINE_RX = uartrb_pkg::REQ_LINE_RX;
    localparam uartrb_pkg::t_req_kind EV_TX_DONE = uartrb_pkg::REQ_TX_DONE;
    localparam uartrb_pkg::t_req_kind EV_HOST_WR = uartrb_pkg::REQ_HOST_WR;
    localparam uartrb_pkg::t_req_kind EV_HOST_RD = uartrb_pkg::REQ_HOST_RD;

    // Same bit layout as m_axis_tdata, pad on top
    typedef struct packed {
        logic [6:0] pad;
        logic [5:0] tx_level;
        logic [5:0] rx_level;
        logic       tx_busy;
        logic       tx_reject;
        logic       rx_overflow;
        logic [7:0] line_byte;
        logic       line_load;
        logic       read_valid;
        logic [7:0] read_byte;
    } t_uart_result;

    typedef struct {
        uartrb_pkg::t_req_kind kind;
        logic [7:0]            data;
        int                    reps;
        bit                    typed;
        t_uart_result          exp;
    } t_event_row;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = '0;   // [7:0] byte_in
    logic [1:0]          s_axis_tuser  = '0;   // [1:0] req_type
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [7:0] read_byte, [8] read_valid, [9] line_load, [17:10] line_byte,
    // [18] rx_overflow, [19] tx_reject, [20] tx_busy, [26:21] rx_level,
    // [32:27] tx_level, [39:33] zero
    logic [uartrb_pkg::OUT_W-1:0] m_axis_tdata;

    // sideband that travels with the item on the bus
    logic                row_typed = 1'b0;
    t_uart_result        row_exp   = '0;

    uart_rx_tx_ring_buffers_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Buffer model
    // ------------------------------------------------------------------
    logic [7:0]   rx_mem [DEPTH];
    logic [7:0]   tx_mem [DEPTH];
    int           rx_head = 0, rx_tail = 0, rx_count = 0;
    int           tx_head = 0, tx_tail = 0, tx_count = 0;
    logic         tx_sending = 1'b0;

    t_uart_result awaited_results[$];
    int           mismatches  = 0;
    int           cycle_count = 0;
    t_event_row   event_table[$];
    int           burst_left  = 0;

    function automatic int wrap_inc(input int idx);
        return (idx + 1 >= DEPTH) ? 0 : idx + 1;
    endfunction

    function automatic t_uart_result uart_buffers_step(input uartrb_pkg::t_req_kind kind,
                                                       input logic [7:0] data);
        t_uart_result r;
        r = '0;
        case (kind)
            uartrb_pkg::REQ_LINE_RX: begin
                if (rx_count < DEPTH) begin
                    rx_mem[rx_tail] = data;
                    rx_tail         = wrap_inc(rx_tail);
                    rx_count++;
                end else begin
                    r.rx_overflow = 1'b1;
                end
            end
            uartrb_pkg::REQ_TX_DONE: begin
                if (tx_count != 0) begin
                    r.line_load = 1'b1;
                    r.line_byte = tx_mem[tx_head];
                    tx_head     = wrap_inc(tx_head);
                    tx_count--;
                end else begin
                    tx_sending = 1'b0;
                end
            end
            uartrb_pkg::REQ_HOST_WR: begin
                // full check comes ahead of the idle test
                if (tx_count >= DEPTH) begin
                    r.tx_reject = 1'b1;
                end else if (!tx_sending) begin
                    r.line_load = 1'b1;
                    r.line_byte = data;
                    tx_sending  = 1'b1;
                end else begin
                    tx_mem[tx_tail] = data;
                    tx_tail         = wrap_inc(tx_tail);
                    tx_count++;
                end
            end
            default: begin
                if (rx_count != 0) begin
                    r.read_valid = 1'b1;
                    r.read_byte  = rx_mem[rx_head];
                    rx_head      = wrap_inc(rx_head);
                    rx_count--;
                end
            end
        endcase
        r.tx_busy  = tx_sending;
        r.rx_level = 6'(rx_count);
        r.tx_level = 6'(tx_count);
        return r;
    endfunction

    function automatic t_uart_result result_of(input logic [7:0] rd_byte, input int rd_valid,
                                               input int ld, input logic [7:0] ld_byte,
                                               input int ovf, input int rej,
                                               input int busy, input int rxl, input int txl);
        t_uart_result r;
        r             = '0;
        r.read_byte   = rd_byte;
        r.read_valid  = 1'(rd_valid);
        r.line_load   = 1'(ld);
        r.line_byte   = ld_byte;
        r.rx_overflow = 1'(ovf);
        r.tx_reject   = 1'(rej);
        r.tx_busy     = 1'(busy);
        r.rx_level    = 6'(rxl);
        r.tx_level    = 6'(txl);
        return r;
    endfunction

    function automatic string fmt_result(input t_uart_result r);
        return $sformatf("rd=%b/%h ld=%b/%h ovf=%b rej=%b busy=%b rx=%0d tx=%0d pad=%h",
                         r.read_valid, r.read_byte, r.line_load, r.line_byte,
                         r.rx_overflow, r.tx_reject, r.tx_busy, r.rx_level,
                         r.tx_level, r.pad);
    endfunction

    // ------------------------------------------------------------------
    // Input transfers feed the model, output transfers are checked
    // ------------------------------------------------------------------
    t_uart_result pred_res, got_res;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pred_res = uart_buffers_step(uartrb_pkg::t_req_kind'(s_axis_tuser),
                                             s_axis_tdata);
                awaited_results.push_back(row_typed ? row_exp : pred_res);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_res = m_axis_tdata;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %s", fmt_result(got_res));
                end else begin
                    pred_res = awaited_results.pop_front();
                    if (got_res !== pred_res) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp: %s", fmt_result(pred_res));
                            $display("         got: %s", fmt_result(got_res));
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern, picked at random
    // ------------------------------------------------------------------
    int rdy_cyc  = 0;
    int rdy_mode = 0;

    always @(posedge i_clk) begin
        rdy_cyc++;
        if (rdy_cyc % 250 == 0)
            rdy_mode = $urandom_range(0, 3);
        case (rdy_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (rdy_cyc % 5) != 0;
            default: m_axis_tready <= (rdy_cyc % 20) >= 15;
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("uart_rx_tx_ring_buffers_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_row(input uartrb_pkg::t_req_kind kind, input logic [7:0] data,
                           input int reps, input int typed, input t_uart_result exp);
        t_event_row row;
        row.kind  = kind;
        row.data  = data;
        row.reps  = reps;
        row.typed = 1'(typed);
        row.exp   = exp;
        event_table.push_back(row);
    endtask

    // One transfer; gaps fall between bursts
    task automatic send_event(input uartrb_pkg::t_req_kind kind, input logic [7:0] data,
                              input bit typed, input t_uart_result exp);
        int gap, r;
        if (burst_left == 0) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                gap = 0;
            else if (r < 9)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(10, 25);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        row_typed     <= typed;
        row_exp       <= exp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // Mode biases the kind mix so both FIFOs fill up and drain regularly
    function automatic uartrb_pkg::t_req_kind pick_kind(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:       return (r < 70) ? EV_LINE_RX : (r < 80) ? EV_HOST_RD :
                            (r < 90) ? EV_HOST_WR : EV_TX_DONE;
            1:       return (r < 70) ? EV_HOST_RD : (r < 85) ? EV_LINE_RX :
                            (r < 93) ? EV_HOST_WR : EV_TX_DONE;
            2:       return (r < 70) ? EV_HOST_WR : (r < 80) ? EV_TX_DONE :
                            (r < 90) ? EV_LINE_RX : EV_HOST_RD;
            3:       return (r < 70) ? EV_TX_DONE : (r < 85) ? EV_HOST_WR :
                            (r < 93) ? EV_LINE_RX : EV_HOST_RD;
            default: return uartrb_pkg::t_req_kind'(2'(r));
        endcase
    endfunction

    initial begin
        int         k, n, mode, mode_left;
        t_event_row row;

        // empty read and transmit done while idle
        add_row(EV_HOST_RD, 8'h5A, 1, 1, result_of(8'h00, 0, 0, 8'h00, 0, 0, 0, 0, 0));
        add_row(EV_TX_DONE, 8'hFF, 1, 1, result_of(8'h00, 0, 0, 8'h00, 0, 0, 0, 0, 0));
        add_row(EV_LINE_RX, 8'h00, 1, 1, result_of(8'h00, 0, 0, 8'h00, 0, 0, 0, 1, 0));
        add_row(EV_LINE_RX, 8'hFF, 1, 1, result_of(8'h00, 0, 0, 8'h00, 0, 0, 0, 2, 0));
        add_row(EV_HOST_RD, 8'h00, 1, 1, result_of(8'h00, 1, 0, 8'h00, 0, 0, 0, 1, 0));
        add_row(EV_HOST_RD, 8'hFF, 1, 1, result_of(8'hFF, 1, 0, 8'h00, 0, 0, 0, 0, 0));
        // write while idle goes straight to the line
        add_row(EV_HOST_WR, 8'hFF, 1, 1, result_of(8'h00, 0, 1, 8'hFF, 0, 0, 1, 0, 0));
        add_row(EV_HOST_WR, 8'h00, 1, 1, result_of(8'h00, 0, 0, 8'h00, 0, 0, 1, 0, 1));
        // pop keeps the busy mark
        add_row(EV_TX_DONE, 8'hA5, 1, 1, result_of(8'h00, 0, 1, 8'h00, 0, 0, 1, 0, 0));
        add_row(EV_TX_DONE, 8'h00, 1, 1, result_of(8'h00, 0, 0, 8'h00, 0, 0, 0, 0, 0));
        add_row(EV_TX_DONE, 8'h3C, 1, 1, result_of(8'h00, 0, 0, 8'h00, 0, 0, 0, 0, 0));
        // fill rx, overflow, drain through the wrap
        add_row(EV_LINE_RX, 8'h80, DEPTH, 0, '0);
        add_row(EV_LINE_RX, 8'h55, 1, 1, result_of(8'h00, 0, 0, 8'h00, 1, 0, 0, 32, 0));
        add_row(EV_HOST_RD, 8'hC3, DEPTH, 0, '0);
        add_row(EV_HOST_RD, 8'h00, 1, 1, result_of(8'h00, 0, 0, 8'h00, 0, 0, 0, 0, 0));
        // fill tx queue behind a busy line, then reject
        add_row(EV_HOST_WR, 8'h11, 1, 1, result_of(8'h00, 0, 1, 8'h11, 0, 0, 1, 0, 0));
        add_row(EV_HOST_WR, 8'hC0, DEPTH, 0, '0);
        add_row(EV_HOST_WR, 8'h22, 1, 1, result_of(8'h00, 0, 0, 8'h00, 0, 1, 1, 0, 32));
        add_row(EV_LINE_RX, 8'h7E, 1, 0, '0);
        add_row(EV_TX_DONE, 8'h99, DEPTH, 0, '0);
        add_row(EV_TX_DONE, 8'h00, 1, 1, result_of(8'h00, 0, 0, 8'h00, 0, 0, 0, 1, 0));
        add_row(EV_HOST_RD, 8'h00, 1, 0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (event_table[i]) begin
            row = event_table[i];
            for (n = 0; n < row.reps; n++)
                send_event(row.kind, row.data + 8'(n), row.typed, row.exp);
        end
        hold_until_drained();

        mode_left = 0;
        mode      = 0;
        for (k = 0; k < RAND_EVENTS; k++) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 4);
                mode_left = $urandom_range(30, 120);
            end
            mode_left--;
            if (k == RAND_EVENTS / 2)
                hold_until_drained();
            send_event(pick_kind(mode), 8'($urandom_range(0, 255)), 1'b0, '0);
        end

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("uart_rx_tx_ring_buffers_top verification clean");
        else
            $display("uart_rx_tx_ring_buffers_top verification failed");
        $finish;
    end

endmodule
